// ===== hdl/gia_pkg.sv =====
// ----------------------------------------------------------------------------
// gia_pkg: shared types and codes for the growable item array
// Beat layouts of the request and response channels, operation and status
// codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package gia_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int INDEX_W   = 6;
	localparam int STATUS_W  = 3;
	localparam int TOTAL_W   = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam int DEPTH_DEF = 64;

	// operation codes
	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
	localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOROOM   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_BLOCK     = 2'd1;

	localparam logic [CFG_W-1:0] RST_INITIAL_CAPACITY = 7'd16;
	localparam logic [CFG_W-1:0] RST_GROWTH_BLOCK     = 7'd4;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [DATA_W-1:0]  value;
		logic [INDEX_W-1:0]        index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [DATA_W-1:0]  data;
		logic [TOTAL_W-1:0]        item_total;
	} rsp_t;

endpackage

// ===== hdl/gia_mem.sv =====
// ----------------------------------------------------------------------------
// gia_mem: item storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gia_mem #(
	parameter int DEPTH  = gia_pkg::DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [ADDR_W-1:0]               waddr,
	input  logic signed [gia_pkg::DATA_W-1:0] wdata,
	input  logic                            re,
	input  logic [ADDR_W-1:0]               raddr,
	output logic signed [gia_pkg::DATA_W-1:0] rdata
);

	logic signed [gia_pkg::DATA_W-1:0] mem [DEPTH];
	logic signed [gia_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/gia_seq.sv =====
// ----------------------------------------------------------------------------
// gia_seq: operation sequencer
// Holds count, capacity and configuration, and steps the storage through
// one operation at a time: a pipelined search pass and a shift-down pass
// for delete, single accesses for the other operations.
// ----------------------------------------------------------------------------
module gia_seq #(
	parameter int DEPTH  = gia_pkg::DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  gia_pkg::req_t                      req,
	input  logic                               cfg_wr_en,
	input  logic [gia_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gia_pkg::CFG_W-1:0]          cfg_data,
	output logic                               mem_we,
	output logic [ADDR_W-1:0]                  mem_waddr,
	output logic signed [gia_pkg::DATA_W-1:0]  mem_wdata,
	output logic                               mem_re,
	output logic [ADDR_W-1:0]                  mem_raddr,
	input  logic signed [gia_pkg::DATA_W-1:0]  mem_rdata,
	output logic                               done_valid,
	input  logic                               done_take,
	output gia_pkg::rsp_t                      done_rsp
);

	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CFG_W   = gia_pkg::CFG_W;
	localparam int WIDE_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
	localparam int TOTAL_W = gia_pkg::TOTAL_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		if (w == '0) begin
			w = WIDE_W'(1);
		end
		if (w > WIDE_W'(DEPTH)) begin
			w = WIDE_W'(DEPTH);
		end
		return CNT_W'(w);
	endfunction

	logic [2:0]                       state_q;
	gia_pkg::req_t                    req_q;
	logic [CFG_W-1:0]                 init_q;
	logic [CFG_W-1:0]                 growth_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 cap_q;
	logic [CNT_W-1:0]                 ptr_q;
	logic [CNT_W-1:0]                 tag_q;
	logic                             pend_q;
	logic [gia_pkg::STATUS_W-1:0]     res_status_q;
	logic signed [gia_pkg::DATA_W-1:0] res_data_q;

	logic [CNT_W-1:0]  init_eff;
	logic [WIDE_W-1:0] count_w;
	logic [WIDE_W-1:0] cap_w;
	logic [WIDE_W-1:0] idx_w;
	logic [WIDE_W-1:0] grown_w;
	logic              idx_ok;
	logic              full;
	logic              append_ok;
	logic              match;
	logic              ptr_in;

	assign init_eff  = clamp_cap(init_q);
	assign count_w   = WIDE_W'(count_q);
	assign cap_w     = WIDE_W'(cap_q);
	assign idx_w     = WIDE_W'(req_q.index);
	assign grown_w   = cap_w + WIDE_W'(growth_q);
	assign idx_ok    = idx_w < count_w;
	assign full      = count_w >= cap_w;
	assign append_ok = !full || ((growth_q != '0) && (grown_w <= WIDE_W'(DEPTH)));
	// shared compare: item under test against the searched value
	assign match     = pend_q && (mem_rdata == req_q.value);
	assign ptr_in    = ptr_q < count_q;

	assign req_stall  = (state_q != S_IDLE);
	assign done_valid = (state_q == S_FIN);

	always_comb begin
		done_rsp.status     = res_status_q;
		done_rsp.data       = res_data_q;
		done_rsp.item_total = TOTAL_W'(count_q);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = req_q.value;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_EXEC: begin
				if (req_q.op == gia_pkg::OP_APPEND && append_ok) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[ADDR_W-1:0];
				end else if (req_q.op == gia_pkg::OP_WRITE && idx_ok) begin
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(idx_w);
				end else if (req_q.op == gia_pkg::OP_READ && idx_ok) begin
					mem_re    = 1'b1;
					mem_raddr = ADDR_W'(idx_w);
				end
			end
			S_SCAN: begin
				mem_re    = ptr_in && !match;
				mem_raddr = ptr_q[ADDR_W-1:0];
			end
			S_SHIFT: begin
				// read one ahead, write the previous beat one place down
				mem_re    = ptr_in;
				mem_raddr = ptr_q[ADDR_W-1:0];
				mem_we    = pend_q;
				mem_waddr = tag_q[ADDR_W-1:0];
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			init_q   <= gia_pkg::RST_INITIAL_CAPACITY;
			growth_q <= gia_pkg::RST_GROWTH_BLOCK;
			count_q  <= '0;
			cap_q    <= clamp_cap(gia_pkg::RST_INITIAL_CAPACITY);
			ptr_q    <= '0;
			tag_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					gia_pkg::CFG_INITIAL_CAPACITY: begin
						init_q  <= cfg_data;
						count_q <= '0;
						cap_q   <= clamp_cap(cfg_data);
					end
					gia_pkg::CFG_GROWTH_BLOCK: begin
						growth_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_status_q <= gia_pkg::ST_OK;
					res_data_q   <= '0;
					state_q      <= S_FIN;
					unique case (req_q.op)
						gia_pkg::OP_APPEND: begin
							if (!full) begin
								count_q <= count_q + 1'b1;
							end else if (growth_q == '0) begin
								res_status_q <= gia_pkg::ST_FULL;
							end else if (grown_w > WIDE_W'(DEPTH)) begin
								res_status_q <= gia_pkg::ST_NOROOM;
							end else begin
								cap_q   <= CNT_W'(grown_w);
								count_q <= count_q + 1'b1;
							end
						end
						gia_pkg::OP_DELETE: begin
							ptr_q   <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SCAN;
						end
						gia_pkg::OP_READ: begin
							if (idx_ok) begin
								state_q <= S_RDWAIT;
							end else begin
								res_status_q <= gia_pkg::ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
				S_RDWAIT: begin
					res_data_q <= mem_rdata;
					state_q    <= S_FIN;
				end
				S_SCAN: begin
					if (match) begin
						res_data_q <= mem_rdata;
						ptr_q      <= tag_q + 1'b1;
						pend_q     <= 1'b0;
						state_q    <= S_SHIFT;
					end else if (ptr_in) begin
						ptr_q  <= ptr_q + 1'b1;
						tag_q  <= ptr_q;
						pend_q <= 1'b1;
					end else begin
						pend_q       <= 1'b0;
						res_status_q <= gia_pkg::ST_NOTFOUND;
						state_q      <= S_FIN;
					end
				end
				S_SHIFT: begin
					if (ptr_in) begin
						ptr_q  <= ptr_q + 1'b1;
						tag_q  <= ptr_q - 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						count_q <= count_q - 1'b1;
						// capacity above count plus one after the removal and above the initial capacity
						if (cap_q > count_q && cap_q > init_eff) begin
							cap_q <= cap_q - 1'b1;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (done_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("item count above capacity");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (cap_w <= WIDE_W'(DEPTH)))
		else $error("capacity out of range");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid) |=> (state_q == S_EXEC))
		else $error("accepted beat not executed");

	a_shift_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && mem_we) |-> (tag_q < count_q))
		else $error("shift write beyond item count");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !done_take) |=> (state_q == S_FIN))
		else $error("result dropped before hand-off");
`endif

endmodule

// ===== hdl/growable_item_array.sv =====
// ----------------------------------------------------------------------------
// growable_item_array: packed array of signed words with block growth
// Request channel (req_valid/req_stall/req) carries one operation per beat:
// append, delete first match, read by index, write by index, count query.
// Response channel (rsp_valid/rsp_stall/rsp) returns one beat per request
// with status, data and the item count after the operation.
// Configuration is a plain write port (cfg_wr_en/cfg_index/cfg_data):
// index 0 sets the initial capacity and empties the array, index 1 sets
// the growth step. Write it only while no request is in flight.
// One request is handled at a time; req_stall is high while it runs.
// Read passes through an extra state that waits for the registered read data.
// Delete runs a search pass over the storage read port, one entry per
// cycle, then, on a hit, a shift pass that moves the later items down
// one per cycle. The next request is taken at the earliest with the
// previous response.
// The response sits in an output register; a stalled response holds and
// the next request is still taken while it waits.
// Reset empties the array and restores capacity 16 and growth step 4.
// ----------------------------------------------------------------------------
module growable_item_array #(
	parameter int DEPTH = gia_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  gia_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output gia_pkg::rsp_t                  rsp,
	input  logic                           cfg_wr_en,
	input  logic [gia_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gia_pkg::CFG_W-1:0]      cfg_data
);

	localparam int ADDR_W = $clog2(DEPTH);

	logic                              mem_we;
	logic [ADDR_W-1:0]                 mem_waddr;
	logic signed [gia_pkg::DATA_W-1:0] mem_wdata;
	logic                              mem_re;
	logic [ADDR_W-1:0]                 mem_raddr;
	logic signed [gia_pkg::DATA_W-1:0] mem_rdata;
	logic                              done_valid;
	logic                              done_take;
	gia_pkg::rsp_t                     done_rsp;
	logic                              rsp_valid_q;
	gia_pkg::rsp_t                     rsp_q;

	gia_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gia_seq #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.done_valid (done_valid),
		.done_take  (done_take),
		.done_rsp   (done_rsp)
	);

	// output register frees as soon as its beat is taken
	assign done_take = done_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_take) begin
			rsp_q <= done_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sv/growable_item_array_tb.sv =====
// ----------------------------------------------------------------------------
// growable_item_array_tb: self-checking bench for the growable item array
// Each test drives operations through the request channel and keeps a
// mirror of the array, count and capacity. The mirror predicts every
// response, and a checker compares each response beat field by field in
// order. Both sides insert random gaps, the receiver also holds off for a
// long stretch, and configuration changes are made only when the block is idle.
// ----------------------------------------------------------------------------
module growable_item_array_tb;
	import gia_pkg::*;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int REPORT_MAX    = 10;
	localparam int SETTLE_CYCLES = 8;

	// op codes the block ignores and register indexes with nothing behind them
	localparam logic [OP_W-1:0]      OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0]      OP_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// mirror of the array
	logic signed [DATA_W-1:0] mirror_items [DEPTH];
	int                       mirror_count;
	int                       mirror_cap;
	logic [CFG_W-1:0]         mirror_init;
	logic [CFG_W-1:0]         mirror_growth;

	rsp_t awaited_rsp [$];

	bit req_gaps_on;
	bit rsp_gaps_on;
	bit hold_rsp_now;
	int fail_count;
	int req_count;
	int rsp_count;
	int setting_count;
	int peak_count;
	int idle_cycles;
	int status_hits [8];

	growable_item_array #(
		.DEPTH(DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int floor_capacity();
		int v;
		v = int'(mirror_init);
		if (v < 1) v = 1;
		if (v > DEPTH) v = DEPTH;
		return v;
	endfunction

	function automatic void mirror_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		if (idx == CFG_INITIAL_CAPACITY) begin
			mirror_init  = val;
			mirror_count = 0;
			mirror_cap   = floor_capacity();
		end else if (idx == CFG_GROWTH_BLOCK) begin
			mirror_growth = val;
		end
	endfunction

	// applies one operation to the mirror and returns the response it owes
	function automatic rsp_t array_outcome(req_t r);
		rsp_t res;
		int   pos;
		int   i;
		res.status = ST_OK;
		res.data   = '0;
		case (r.op)
			OP_APPEND: begin
				if (mirror_count >= mirror_cap) begin
					if (mirror_growth == '0)
						res.status = ST_FULL;
					else if (mirror_cap + int'(mirror_growth) > DEPTH)
						res.status = ST_NOROOM;
					else
						mirror_cap += int'(mirror_growth);
				end
				if (res.status == ST_OK && mirror_count < DEPTH) begin
					mirror_items[mirror_count] = r.value;
					mirror_count++;
				end
			end
			OP_DELETE: begin
				pos = -1;
				for (i = 0; i < mirror_count; i++)
					if (pos < 0 && mirror_items[i] == r.value) pos = i;
				if (pos < 0) begin
					res.status = ST_NOTFOUND;
				end else begin
					res.data = mirror_items[pos];
					for (i = pos; i + 1 < mirror_count; i++)
						mirror_items[i] = mirror_items[i + 1];
					mirror_count--;
					if (mirror_cap - mirror_count > 1 && mirror_cap > floor_capacity())
						mirror_cap--;
				end
			end
			OP_READ: begin
				if (int'(r.index) < mirror_count)
					res.data = mirror_items[r.index];
				else
					res.status = ST_RANGE;
			end
			OP_WRITE: begin
				if (int'(r.index) < mirror_count) mirror_items[r.index] = r.value;
			end
			default: ;
		endcase
		res.item_total = mirror_count[TOTAL_W-1:0];
		if (mirror_count > peak_count) peak_count = mirror_count;
		return res;
	endfunction

	function automatic int pick_gap(bit on);
		int r;
		if (!on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return WORD_MIN;
				1: return WORD_MAX;
				2: return -1;
				default: return 0;
			endcase
		end
		// small pool so that duplicates show up often
		if (r < 4) begin
			v = $urandom_range(0, 7);
			return v - 3;
		end
		return $urandom;
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		if (mirror_count > 0 && $urandom_range(0, 5) != 0)
			return INDEX_W'($urandom_range(0, mirror_count - 1));
		return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
	endfunction

	function automatic void flag(string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) $display("%s", msg);
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
			logic [INDEX_W-1:0] idx);
		req_t beat;
		int   gap;
		beat.op    = op;
		beat.value = value;
		beat.index = idx;
		gap = pick_gap(req_gaps_on);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		do @(posedge clk); while (req_stall);
		awaited_rsp.push_back(array_outcome(beat));
		req_count++;
	endtask

	// sender stops until every owed response is back
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(bit write_init, logic [CFG_W-1:0] init_v,
			logic [CFG_W-1:0] grow_v, bit poke_spare);
		logic [CFG_W-1:0] spare;
		wait_idle();
		cfg_wr_en <= 1'b1;
		if (write_init) begin
			cfg_index <= CFG_INITIAL_CAPACITY;
			cfg_data  <= init_v;
			@(posedge clk);
			mirror_config(CFG_INITIAL_CAPACITY, init_v);
		end
		cfg_index <= CFG_GROWTH_BLOCK;
		cfg_data  <= grow_v;
		@(posedge clk);
		mirror_config(CFG_GROWTH_BLOCK, grow_v);
		if (poke_spare) begin
			spare = CFG_W'($urandom_range(0, 127));
			cfg_index <= CFG_SPARE_2;
			cfg_data  <= spare;
			@(posedge clk);
			mirror_config(CFG_SPARE_2, spare);
			spare = CFG_W'($urandom_range(0, 127));
			cfg_index <= CFG_SPARE_3;
			cfg_data  <= spare;
			@(posedge clk);
			mirror_config(CFG_SPARE_3, spare);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		setting_count++;
	endtask

	task automatic run_mix(int n, int pct_append, int pct_delete);
		int                       r;
		int                       sel;
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] value;
		logic [INDEX_W-1:0]       idx;
		repeat (n) begin
			r     = $urandom_range(0, 99);
			value = pick_value();
			idx   = pick_index();
			if (r < pct_append) begin
				op = OP_APPEND;
			end else if (r < pct_append + pct_delete) begin
				op = OP_DELETE;
				// mostly aim at a value that is actually held
				if (mirror_count > 0 && $urandom_range(0, 3) != 0)
					value = mirror_items[$urandom_range(0, mirror_count - 1)];
			end else begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				else if (sel < 3)
					op = OP_COUNT;
				else if (sel < 12)
					op = OP_READ;
				else
					op = OP_WRITE;
			end
			send_item(op, value, idx);
		end
	endtask

	task automatic test_directed_basics();
		send_item(OP_COUNT, 0, 0);
		send_item(OP_READ, 0, 0);
		send_item(OP_READ, 0, 63);
		send_item(OP_DELETE, 0, 0);
		send_item(OP_APPEND, WORD_MIN, 0);
		send_item(OP_APPEND, WORD_MAX, 0);
		send_item(OP_APPEND, -1, 0);
		send_item(OP_APPEND, 0, 0);
		send_item(OP_APPEND, -1, 0);
		send_item(OP_READ, 0, 0);
		send_item(OP_READ, 0, 4);
		send_item(OP_WRITE, 32'sh1234_5678, 3);
		send_item(OP_WRITE, 1, 63);
		// first of two equal items goes, the rest move down
		send_item(OP_DELETE, -1, 0);
		send_item(OP_READ, 0, 2);
		send_item(OP_SPARE_LO, $urandom, INDEX_W'($urandom_range(0, 63)));
		send_item(OP_SPARE_LO + 3'd1, $urandom, INDEX_W'($urandom_range(0, 63)));
		send_item(OP_SPARE_HI, $urandom, INDEX_W'($urandom_range(0, 63)));
	endtask

	task automatic test_default_mix();
		run_mix(200, 55, 15);
	endtask

	task automatic test_full_and_no_room();
		set_config(1'b1, 7'd2, 7'd0, 1'b0);
		send_item(OP_APPEND, 11, 0);
		send_item(OP_APPEND, 22, 0);
		send_item(OP_APPEND, 33, 0);
		// growth step alone changes, the array stays
		set_config(1'b0, '0, 7'd127, 1'b0);
		send_item(OP_APPEND, 44, 0);
		send_item(OP_COUNT, 0, 0);
	endtask

	task automatic test_backpressure();
		set_config(1'b1, 7'd8, 7'd4, 1'b0);
		req_gaps_on  = 1'b0;
		hold_rsp_now = 1'b1;
		run_mix(40, 50, 20);
		req_gaps_on = 1'b1;
	endtask

	task automatic test_tiny_no_growth();
		set_config(1'b1, 7'd1, 7'd0, 1'b1);
		run_mix(150, 45, 20);
	endtask

	task automatic test_unit_growth();
		// zero initial capacity is taken as one
		set_config(1'b1, 7'd0, 7'd1, 1'b0);
		run_mix(200, 60, 10);
	endtask

	task automatic test_deep_no_growth();
		// beyond the store size the initial capacity is taken as the store size
		set_config(1'b1, 7'd127, 7'd0, 1'b0);
		run_mix(250, 65, 10);
	endtask

	task automatic test_oversize_growth_no_gaps();
		set_config(1'b1, 7'd5, 7'd127, 1'b1);
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		run_mix(150, 50, 15);
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
	endtask

	task automatic test_full_step();
		set_config(1'b1, 7'd64, 7'd64, 1'b0);
		run_mix(150, 50, 20);
	endtask

	task automatic test_fill_drain();
		// growth lands exactly on the store size, then shrinks back on deletes
		set_config(1'b1, 7'd33, 7'd31, 1'b0);
		run_mix(100, 85, 5);
		run_mix(100, 5, 70);
	endtask

	task automatic test_random_settings();
		logic [CFG_W-1:0] grow_v;
		repeat (4) begin
			if ($urandom_range(0, 3) == 0)
				grow_v = CFG_W'($urandom_range(0, 127));
			else
				grow_v = CFG_W'($urandom_range(0, 8));
			set_config(1'b1, CFG_W'($urandom_range(0, 127)), grow_v,
				1'($urandom_range(0, 1)));
			run_mix(75, $urandom_range(30, 75), 15);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin : rsp_side
		int n;
		rsp_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_rsp_now) begin
				hold_rsp_now = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap(rsp_gaps_on);
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (awaited_rsp.size() == 0) begin
				flag($sformatf("response %0d with none owed: status %0d data %0d total %0d",
					rsp_count, rsp.status, rsp.data, rsp.item_total));
			end else begin
				want = awaited_rsp.pop_front();
				status_hits[want.status]++;
				if (rsp.status !== want.status)
					flag($sformatf("response %0d status: expected %0d, got %0d",
						rsp_count, want.status, rsp.status));
				if (rsp.data !== want.data)
					flag($sformatf("response %0d data: expected %0d, got %0d",
						rsp_count, want.data, rsp.data));
				if (rsp.item_total !== want.item_total)
					flag($sformatf("response %0d item_total: expected %0d, got %0d",
						rsp_count, want.item_total, rsp.item_total));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d responses owed",
					IDLE_LIMIT, awaited_rsp.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		cfg_wr_en   = 1'b0;
		cfg_index   = CFG_INITIAL_CAPACITY;
		cfg_data    = '0;
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		mirror_init   = RST_INITIAL_CAPACITY;
		mirror_growth = RST_GROWTH_BLOCK;
		mirror_count  = 0;
		mirror_cap    = floor_capacity();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_default_mix();
		test_full_and_no_room();
		test_backpressure();
		test_tiny_no_growth();
		test_unit_growth();
		test_deep_no_growth();
		test_oversize_growth_no_gaps();
		test_full_step();
		test_fill_drain();
		test_random_settings();

		wait_idle();
		repeat (DEPTH + SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests, %0d settings, %0d responses checked, peak %0d items",
			req_count, setting_count + 1, rsp_count, peak_count);
		$display("status seen: full %0d, no room %0d, not found %0d, out of range %0d",
			status_hits[ST_FULL], status_hits[ST_NOROOM], status_hits[ST_NOTFOUND],
			status_hits[ST_RANGE]);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
